// File: rtl/bresenham_line_pixel_stepper_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line pixel stepper
// Shared forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_MACROS_SVH

// Checks that prop holds in the same cycle in which cond holds.
`define BLPS_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("blps: same-cycle check failed");

// Checks that prop holds in the cycle after cond holds.
`define BLPS_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("blps: next-cycle check failed");

`endif

// File: rtl/blps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line pixel stepper package
// Fixed field widths, register indexes and control structs.
// ---------------------------------------------------------------------------
package blps_pkg;

	localparam int SCREEN_BITS    = 10;
	localparam int OFFSET_BITS    = 20;
	localparam int COLOR_BITS     = 16;
	localparam int ALPHA_BITS     = 8;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 10'd320;
	localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 10'd240;

	// One point leaving the walker.
	typedef struct packed {
		logic valid;
		logic last;
	} pix_ctl_t;

	// Walker status seen at the top level.
	typedef struct packed {
		logic busy;
		logic load;
	} walk_stat_t;

	// Queue fill status.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: rtl/blps_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Small synchronous queue
// Register-based FIFO with a power-of-two depth and a fill count.
// ---------------------------------------------------------------------------
module blps_fifo import blps_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output q_stat_t          stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.full  = (count_q == (AW+1)'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

// File: rtl/blps_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line command front end
// Registers one line request and derives its deltas, step directions and
// initial error before it enters the command queue.
// ---------------------------------------------------------------------------
module blps_front import blps_pkg::*; #(
	parameter int COORD_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	input  logic [COLOR_BITS-1:0]         line_color,
	input  logic [ALPHA_BITS-1:0]         line_alpha,
	input  q_stat_t                       cq_stat,
	output logic                          cq_wr,
	output logic signed [COORD_BITS-1:0]  c_sx,
	output logic signed [COORD_BITS-1:0]  c_sy,
	output logic signed [COORD_BITS-1:0]  c_ex,
	output logic signed [COORD_BITS-1:0]  c_ey,
	output logic signed [COORD_BITS:0]    c_dx,
	output logic signed [COORD_BITS:0]    c_dy,
	output logic                          c_stx_neg,
	output logic                          c_sty_neg,
	output logic signed [COORD_BITS+2:0]  c_err,
	output logic [COLOR_BITS-1:0]         c_color,
	output logic [ALPHA_BITS-1:0]         c_alpha
);

	localparam int DW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;

	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] sx_s1;
	logic signed [COORD_BITS-1:0] sy_s1;
	logic signed [COORD_BITS-1:0] ex_s1;
	logic signed [COORD_BITS-1:0] ey_s1;
	logic [COLOR_BITS-1:0]        color_s1;
	logic [ALPHA_BITS-1:0]        alpha_s1;
	logic                         take;
	logic signed [DW-1:0]         ddx;
	logic signed [DW-1:0]         ddy;

	assign full  = valid_s1 && cq_stat.full;
	assign take  = push && !full;
	assign cq_wr = valid_s1 && !cq_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !cq_wr);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sx_s1    <= start_x;
			sy_s1    <= start_y;
			ex_s1    <= end_x;
			ey_s1    <= end_y;
			color_s1 <= line_color;
			alpha_s1 <= line_alpha;
		end
	end

	assign ddx = DW'(ex_s1) - DW'(sx_s1);
	assign ddy = DW'(ey_s1) - DW'(sy_s1);

	// The x delta is kept positive and the y delta negative, as the error
	// term of the all-octant form expects.
	assign c_dx      = ddx[DW-1] ? -ddx : ddx;
	assign c_dy      = ddy[DW-1] ? ddy : -ddy;
	assign c_err     = EW'(c_dx) + EW'(c_dy);
	assign c_stx_neg = !(sx_s1 < ex_s1);
	assign c_sty_neg = !(sy_s1 < ey_s1);
	assign c_sx      = sx_s1;
	assign c_sy      = sy_s1;
	assign c_ex      = ex_s1;
	assign c_ey      = ey_s1;
	assign c_color   = color_s1;
	assign c_alpha   = alpha_s1;

endmodule

// File: rtl/blps_walker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line walker
// Steps the Bresenham error term one point per cycle unless adv stalls it,
// emits each point with its last flag, and loads the next command as the current one ends.
// ---------------------------------------------------------------------------
module blps_walker import blps_pkg::*; #(
	parameter int COORD_BITS = 11,
	parameter int STEP_LIMIT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  q_stat_t                       cq_stat,
	output logic                          cq_rd,
	input  logic signed [COORD_BITS-1:0]  c_sx,
	input  logic signed [COORD_BITS-1:0]  c_sy,
	input  logic signed [COORD_BITS-1:0]  c_ex,
	input  logic signed [COORD_BITS-1:0]  c_ey,
	input  logic signed [COORD_BITS:0]    c_dx,
	input  logic signed [COORD_BITS:0]    c_dy,
	input  logic                          c_stx_neg,
	input  logic                          c_sty_neg,
	input  logic signed [COORD_BITS+2:0]  c_err,
	input  logic [COLOR_BITS-1:0]         c_color,
	input  logic [ALPHA_BITS-1:0]         c_alpha,
	input  logic                          adv,
	output pix_ctl_t                      pt_ctl,
	output logic signed [COORD_BITS-1:0]  pt_x,
	output logic signed [COORD_BITS-1:0]  pt_y,
	output logic [COLOR_BITS-1:0]         pt_color,
	output logic [ALPHA_BITS-1:0]         pt_alpha,
	output walk_stat_t                    stat
);

	localparam int DW  = COORD_BITS + 1;
	localparam int EW  = COORD_BITS + 3;
	localparam int E2W = EW + 1;
	localparam int SW  = $clog2(STEP_LIMIT + 1);

	logic                         busy_q;
	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [COORD_BITS-1:0] end_x_q;
	logic signed [COORD_BITS-1:0] end_y_q;
	logic signed [DW-1:0]         dx_q;
	logic signed [DW-1:0]         dy_q;
	logic                         stx_neg_q;
	logic                         sty_neg_q;
	logic signed [EW-1:0]         err_q;
	logic [SW-1:0]                steps_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic [ALPHA_BITS-1:0]        alpha_q;

	logic                         emit;
	logic                         reached;
	logic                         last_pt;
	logic                         load;
	logic signed [E2W-1:0]        e2;
	logic                         x_step;
	logic                         y_step;
	logic signed [EW-1:0]         err_nxt;
	logic signed [COORD_BITS-1:0] inc_x;
	logic signed [COORD_BITS-1:0] inc_y;

	assign emit    = busy_q && adv;
	assign reached = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
	assign last_pt = reached || (steps_q == SW'(1));
	assign load    = (!busy_q || (emit && last_pt)) && !cq_stat.empty;
	assign cq_rd   = load;

	assign e2      = {err_q, 1'b0};
	assign x_step  = e2 >= E2W'(dy_q);
	assign y_step  = e2 <= E2W'(dx_q);
	assign err_nxt = err_q + (x_step ? EW'(dy_q) : EW'(0)) + (y_step ? EW'(dx_q) : EW'(0));
	assign inc_x   = stx_neg_q ? '1 : COORD_BITS'(1);
	assign inc_y   = sty_neg_q ? '1 : COORD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (load) begin
			busy_q  <= 1'b1;
			steps_q <= SW'(STEP_LIMIT);
		end else if (emit) begin
			busy_q  <= !last_pt;
			steps_q <= steps_q - SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_x_q   <= c_sx;
			cur_y_q   <= c_sy;
			end_x_q   <= c_ex;
			end_y_q   <= c_ey;
			dx_q      <= c_dx;
			dy_q      <= c_dy;
			stx_neg_q <= c_stx_neg;
			sty_neg_q <= c_sty_neg;
			err_q     <= c_err;
			color_q   <= c_color;
			alpha_q   <= c_alpha;
		end else if (emit && !last_pt) begin
			err_q <= err_nxt;
			if (x_step) begin
				cur_x_q <= cur_x_q + inc_x;
			end
			if (y_step) begin
				cur_y_q <= cur_y_q + inc_y;
			end
		end
	end

	assign pt_ctl.valid = emit;
	assign pt_ctl.last  = last_pt;
	assign pt_x         = cur_x_q;
	assign pt_y         = cur_y_q;
	assign pt_color     = color_q;
	assign pt_alpha     = alpha_q;
	assign stat.busy    = busy_q;
	assign stat.load    = load;

endmodule

// File: rtl/blps_pixel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel clip and address stage
// Clips each point against the screen rectangle, forms its linear offset
// and writes the finished point into the result queue.
// ---------------------------------------------------------------------------
module blps_pixel import blps_pkg::*; #(
	parameter int COORD_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pix_ctl_t                      pt_ctl,
	input  logic signed [COORD_BITS-1:0]  pt_x,
	input  logic signed [COORD_BITS-1:0]  pt_y,
	input  logic [COLOR_BITS-1:0]         pt_color,
	input  logic [ALPHA_BITS-1:0]         pt_alpha,
	input  logic [SCREEN_BITS-1:0]        screen_width,
	input  logic [SCREEN_BITS-1:0]        screen_height,
	input  q_stat_t                       oq_stat,
	output logic                          adv,
	output logic                          oq_wr,
	output logic signed [COORD_BITS-1:0]  o_x,
	output logic signed [COORD_BITS-1:0]  o_y,
	output logic                          o_vis,
	output logic [OFFSET_BITS-1:0]        o_offset,
	output logic [COLOR_BITS-1:0]         o_color,
	output logic [ALPHA_BITS-1:0]         o_alpha,
	output logic                          o_last
);

	localparam int XW = COORD_BITS + SCREEN_BITS;

	logic                         valid_s1;
	logic                         last_s1;
	logic                         vis_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic [OFFSET_BITS-1:0]       prod_s1;
	logic [SCREEN_BITS-1:0]       xlo_s1;
	logic [COLOR_BITS-1:0]        color_s1;
	logic [ALPHA_BITS-1:0]        alpha_s1;

	logic signed [XW-1:0]         xe;
	logic signed [XW-1:0]         ye;
	logic signed [XW-1:0]         we;
	logic signed [XW-1:0]         he;
	logic                         vis;
	logic [OFFSET_BITS-1:0]       prod;

	assign xe   = XW'(pt_x);
	assign ye   = XW'(pt_y);
	assign we   = $signed({{COORD_BITS{1'b0}}, screen_width});
	assign he   = $signed({{COORD_BITS{1'b0}}, screen_height});
	assign vis  = !xe[XW-1] && !ye[XW-1] && (xe < we) && (ye < he);

	// Only the low bits of the row matter: a visible row is below the height.
	assign prod = OFFSET_BITS'(ye[SCREEN_BITS-1:0]) * OFFSET_BITS'(screen_width);

	assign adv   = !(valid_s1 && oq_stat.full);
	assign oq_wr = valid_s1 && !oq_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pt_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1  <= pt_ctl.last;
			vis_s1   <= vis;
			x_s1     <= pt_x;
			y_s1     <= pt_y;
			prod_s1  <= prod;
			xlo_s1   <= xe[SCREEN_BITS-1:0];
			color_s1 <= pt_color;
			alpha_s1 <= pt_alpha;
		end
	end

	assign o_x      = x_s1;
	assign o_y      = y_s1;
	assign o_vis    = vis_s1;
	assign o_offset = vis_s1 ? (prod_s1 + OFFSET_BITS'(xlo_s1)) : '0;
	assign o_color  = color_s1;
	assign o_alpha  = alpha_s1;
	assign o_last   = last_s1;

endmodule

// File: rtl/bresenham_line_pixel_stepper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bresenham line pixel stepper
// Walks an all-octant line from start to end and emits one clipped point
// per visited pixel, with its framebuffer offset and the command's color.
// ---------------------------------------------------------------------------
// A line request yields one result per visited point, from 1 up to STEP_LIMIT
// points, the final one marked last. The walker produces one point per clock
// while results are being popped, and the next queued request starts in the
// cycle after the last point of the previous one. A request passes the front
// end register and the command queue before it reaches the walker, and a point
// passes the pixel stage register and the result queue after the walker emits
// it. A two-entry command queue lets requests be pushed while a line is still
// being walked, and a four-entry result queue lets the walker keep running
// while the consumer pauses briefly.
// The screen registers must only be written while no line is in progress.
// ---------------------------------------------------------------------------
`include "bresenham_line_pixel_stepper_macros.svh"

module bresenham_line_pixel_stepper import blps_pkg::*; #(
	parameter int STEP_LIMIT = 64,
	parameter int COORD_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [SCREEN_BITS-1:0]        cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	input  logic [COLOR_BITS-1:0]         line_color,
	input  logic [ALPHA_BITS-1:0]         line_alpha,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_BITS-1:0]  point_x,
	output logic signed [COORD_BITS-1:0]  point_y,
	output logic                          visible,
	output logic [OFFSET_BITS-1:0]        pixel_offset,
	output logic [COLOR_BITS-1:0]         point_color,
	output logic [ALPHA_BITS-1:0]         point_alpha,
	output logic                          last
);

	localparam int DW     = COORD_BITS + 1;
	localparam int EW     = COORD_BITS + 3;
	localparam int CMD_W  = 4 * COORD_BITS + 2 * DW + 2 + EW + COLOR_BITS + ALPHA_BITS;
	localparam int OUT_W  = 2 * COORD_BITS + 2 + OFFSET_BITS + COLOR_BITS + ALPHA_BITS;
	localparam int CQ_DEPTH = 2;
	localparam int OQ_DEPTH = 4;

	logic [SCREEN_BITS-1:0] screen_width_q;
	logic [SCREEN_BITS-1:0] screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_SCREEN_WIDTH) begin
				screen_width_q <= cfg_data;
			end
			if (cfg_index == REG_SCREEN_HEIGHT) begin
				screen_height_q <= cfg_data;
			end
		end
	end

	// Front end to command queue
	logic                         cq_wr;
	logic                         cq_rd;
	q_stat_t                      cq_stat;
	logic [CMD_W-1:0]             cq_wdata;
	logic [CMD_W-1:0]             cq_rdata;
	logic signed [COORD_BITS-1:0] f_sx, f_sy, f_ex, f_ey;
	logic signed [DW-1:0]         f_dx, f_dy;
	logic                         f_stx_neg, f_sty_neg;
	logic signed [EW-1:0]         f_err;
	logic [COLOR_BITS-1:0]        f_color;
	logic [ALPHA_BITS-1:0]        f_alpha;
	logic signed [COORD_BITS-1:0] w_sx, w_sy, w_ex, w_ey;
	logic signed [DW-1:0]         w_dx, w_dy;
	logic                         w_stx_neg, w_sty_neg;
	logic signed [EW-1:0]         w_err;
	logic [COLOR_BITS-1:0]        w_color;
	logic [ALPHA_BITS-1:0]        w_alpha;

	blps_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.line_color (line_color),
		.line_alpha (line_alpha),
		.cq_stat    (cq_stat),
		.cq_wr      (cq_wr),
		.c_sx       (f_sx),
		.c_sy       (f_sy),
		.c_ex       (f_ex),
		.c_ey       (f_ey),
		.c_dx       (f_dx),
		.c_dy       (f_dy),
		.c_stx_neg  (f_stx_neg),
		.c_sty_neg  (f_sty_neg),
		.c_err      (f_err),
		.c_color    (f_color),
		.c_alpha    (f_alpha)
	);

	assign cq_wdata = {f_sx, f_sy, f_ex, f_ey, f_dx, f_dy, f_stx_neg, f_sty_neg,
		f_err, f_color, f_alpha};

	blps_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CQ_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_wr),
		.wr_data (cq_wdata),
		.rd_en   (cq_rd),
		.rd_data (cq_rdata),
		.stat    (cq_stat)
	);

	assign {w_sx, w_sy, w_ex, w_ey, w_dx, w_dy, w_stx_neg, w_sty_neg,
		w_err, w_color, w_alpha} = cq_rdata;

	// Walker to pixel stage
	logic                         adv;
	pix_ctl_t                     pt_ctl;
	walk_stat_t                   wk_stat;
	logic signed [COORD_BITS-1:0] pt_x, pt_y;
	logic [COLOR_BITS-1:0]        pt_color;
	logic [ALPHA_BITS-1:0]        pt_alpha;

	blps_walker #(
		.COORD_BITS (COORD_BITS),
		.STEP_LIMIT (STEP_LIMIT)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_stat   (cq_stat),
		.cq_rd     (cq_rd),
		.c_sx      (w_sx),
		.c_sy      (w_sy),
		.c_ex      (w_ex),
		.c_ey      (w_ey),
		.c_dx      (w_dx),
		.c_dy      (w_dy),
		.c_stx_neg (w_stx_neg),
		.c_sty_neg (w_sty_neg),
		.c_err     (w_err),
		.c_color   (w_color),
		.c_alpha   (w_alpha),
		.adv       (adv),
		.pt_ctl    (pt_ctl),
		.pt_x      (pt_x),
		.pt_y      (pt_y),
		.pt_color  (pt_color),
		.pt_alpha  (pt_alpha),
		.stat      (wk_stat)
	);

	// Pixel stage to result queue
	logic                         oq_wr;
	q_stat_t                      oq_stat;
	logic [OUT_W-1:0]             oq_wdata;
	logic [OUT_W-1:0]             oq_rdata;
	logic signed [COORD_BITS-1:0] o_x, o_y;
	logic                         o_vis;
	logic [OFFSET_BITS-1:0]       o_offset;
	logic [COLOR_BITS-1:0]        o_color;
	logic [ALPHA_BITS-1:0]        o_alpha;
	logic                         o_last;

	blps_pixel #(
		.COORD_BITS (COORD_BITS)
	) u_pixel (
		.clk           (clk),
		.arst_n        (arst_n),
		.pt_ctl        (pt_ctl),
		.pt_x          (pt_x),
		.pt_y          (pt_y),
		.pt_color      (pt_color),
		.pt_alpha      (pt_alpha),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.oq_stat       (oq_stat),
		.adv           (adv),
		.oq_wr         (oq_wr),
		.o_x           (o_x),
		.o_y           (o_y),
		.o_vis         (o_vis),
		.o_offset      (o_offset),
		.o_color       (o_color),
		.o_alpha       (o_alpha),
		.o_last        (o_last)
	);

	assign oq_wdata = {o_x, o_y, o_vis, o_offset, o_color, o_alpha, o_last};

	blps_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (OQ_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (oq_wr),
		.wr_data (oq_wdata),
		.rd_en   (pop),
		.rd_data (oq_rdata),
		.stat    (oq_stat)
	);

	assign empty = oq_stat.empty;
	assign {point_x, point_y, visible, pixel_offset, point_color, point_alpha, last} = oq_rdata;

	// A hidden point must never carry an address.
	`BLPS_ASSERT_NOW(a_hidden_offset_zero, !empty && !visible, pixel_offset == '0)
	// The walker only starts a line when the command queue holds one.
	`BLPS_ASSERT_NOW(a_load_from_queue, wk_stat.load, !cq_stat.empty)
	// A loaded line always leaves the walker busy in the next cycle.
	`BLPS_ASSERT_NEXT(a_load_sets_busy, wk_stat.load, wk_stat.busy)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line pixel stepper testbench
// Feeds line requests through the push/full side, pops the points from the
// empty/pop side with random stalls and compares every point, field by field,
// against a local Bresenham walk that tracks the screen registers.
// ---------------------------------------------------------------------------
module tb_top;
	import blps_pkg::*;

	localparam int COORD_W        = 11;
	localparam int STEP_COUNT     = 64;
	localparam int COORD_MIN      = -(1 << (COORD_W - 1));
	localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int END_SETTLE     = 32;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic [COLOR_BITS-1:0]     color;
		logic [ALPHA_BITS-1:0]     alpha;
	} line_cmd_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      vis;
		logic [OFFSET_BITS-1:0]    offset;
		logic [COLOR_BITS-1:0]     color;
		logic [ALPHA_BITS-1:0]     alpha;
		logic                      last;
	} line_point_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
	logic [SCREEN_BITS-1:0]       cfg_data = '0;
	logic                         push = 1'b0;
	logic                         full;
	logic signed [COORD_W-1:0]    start_x = '0;
	logic signed [COORD_W-1:0]    start_y = '0;
	logic signed [COORD_W-1:0]    end_x = '0;
	logic signed [COORD_W-1:0]    end_y = '0;
	logic [COLOR_BITS-1:0]        line_color = '0;
	logic [ALPHA_BITS-1:0]        line_alpha = '0;
	logic                         empty;
	logic                         pop = 1'b0;
	logic signed [COORD_W-1:0]    point_x;
	logic signed [COORD_W-1:0]    point_y;
	logic                         visible;
	logic [OFFSET_BITS-1:0]       pixel_offset;
	logic [COLOR_BITS-1:0]        point_color;
	logic [ALPHA_BITS-1:0]        point_alpha;
	logic                         last;

	// Screen size as the pixel stage should currently see it.
	logic [SCREEN_BITS-1:0] scr_width = SCREEN_WIDTH_RST;
	logic [SCREEN_BITS-1:0] scr_height = SCREEN_HEIGHT_RST;

	line_cmd_t   pending_lines[$];
	line_point_t expected_points[$];
	line_cmd_t   offered;
	line_point_t want_pt;

	int fail_count = 0;
	int push_gap;
	int pop_gap;
	int hold_left;
	int quiet_cycles = 0;
	int rx_hold_reqs = 0;
	int rx_holds_done = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	bresenham_line_pixel_stepper #(
		.STEP_LIMIT(STEP_COUNT),
		.COORD_BITS(COORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.line_color(line_color),
		.line_alpha(line_alpha),
		.empty(empty),
		.pop(pop),
		.point_x(point_x),
		.point_y(point_y),
		.visible(visible),
		.pixel_offset(pixel_offset),
		.point_color(point_color),
		.point_alpha(point_alpha),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Walks the line the way the block should and queues every point it visits.
	function automatic void trace_line(input line_cmd_t cmd);
		int cx, cy, tx, ty, dx, dy, stx, sty, err, e2, wd, ht;
		bit reached;
		line_point_t pt;
		cx = cmd.sx;
		cy = cmd.sy;
		tx = cmd.ex;
		ty = cmd.ey;
		wd = scr_width;
		ht = scr_height;
		dx = (tx > cx) ? tx - cx : cx - tx;
		dy = (ty > cy) ? cy - ty : ty - cy;
		stx = (cx < tx) ? 1 : -1;
		sty = (cy < ty) ? 1 : -1;
		err = dx + dy;
		for (int n = 0; n < STEP_COUNT; n++) begin
			reached = (cx == tx) && (cy == ty);
			pt.x = cx[COORD_W-1:0];
			pt.y = cy[COORD_W-1:0];
			pt.vis = (cx >= 0) && (cy >= 0) && (cx < wd) && (cy < ht);
			pt.offset = pt.vis ? OFFSET_BITS'(cy * wd + cx) : '0;
			pt.color = cmd.color;
			pt.alpha = cmd.alpha;
			pt.last = reached || (n == STEP_COUNT - 1);
			expected_points.push_back(pt);
			if (reached)
				break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				cx += stx;
			end
			if (e2 <= dx) begin
				err += dx;
				cy += sty;
			end
		end
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	function automatic line_cmd_t mk_line(input int sx, input int sy, input int ex,
			input int ey, input int color, input int alpha);
		line_cmd_t c;
		c.sx = sx[COORD_W-1:0];
		c.sy = sy[COORD_W-1:0];
		c.ex = ex[COORD_W-1:0];
		c.ey = ey[COORD_W-1:0];
		c.color = color[COLOR_BITS-1:0];
		c.alpha = alpha[ALPHA_BITS-1:0];
		return c;
	endfunction

	// Mostly short lines on and just around the screen, now and then one anywhere.
	function automatic line_cmd_t random_line();
		int x0, y0, x1, y1, reach;
		if ($urandom_range(0, 7) == 0) begin
			x0 = COORD_MIN + int'($urandom_range(0, COORD_MAX - COORD_MIN));
			y0 = COORD_MIN + int'($urandom_range(0, COORD_MAX - COORD_MIN));
			x1 = COORD_MIN + int'($urandom_range(0, COORD_MAX - COORD_MIN));
			y1 = COORD_MIN + int'($urandom_range(0, COORD_MAX - COORD_MIN));
		end else begin
			reach = ($urandom_range(0, 4) == 0) ? 70 : 10;
			x0 = clamp_coord(int'($urandom_range(0, int'(scr_width) + 16)) - 8);
			y0 = clamp_coord(int'($urandom_range(0, int'(scr_height) + 16)) - 8);
			x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
			y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
		end
		return mk_line(x0, y0, x1, y1, int'($urandom_range(0, 65535)),
			int'($urandom_range(0, 255)));
	endfunction

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	// Request driver: offers the pending lines one by one with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			push_gap = 0;
		end else begin
			if (push && !full) begin
				trace_line(offered);
				push_gap = tx_burst ? 0 : $urandom_range(0, 6);
			end
			if (!(push && full)) begin
				if (push_gap > 0) begin
					push_gap--;
					push <= 1'b0;
				end else if (pending_lines.size() > 0) begin
					offered = pending_lines.pop_front();
					start_x <= offered.sx;
					start_y <= offered.sy;
					end_x <= offered.ex;
					end_y <= offered.ey;
					line_color <= offered.color;
					line_alpha <= offered.alpha;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Point monitor: pops with random stalls and checks against the walk.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
			hold_left = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_points.size() == 0) begin
					$error("point (%0d, %0d) popped with no line request pending",
						point_x, point_y);
					fail_count++;
				end else begin
					want_pt = expected_points.pop_front();
					check_field("point_x", want_pt.x, point_x);
					check_field("point_y", want_pt.y, point_y);
					check_field("visible", want_pt.vis, visible);
					check_field("pixel_offset", want_pt.offset, pixel_offset);
					check_field("point_color", want_pt.color, point_color);
					check_field("point_alpha", want_pt.alpha, point_alpha);
					check_field("last", want_pt.last, last);
				end
				pop_gap = rx_burst ? 0 : $urandom_range(0, 6);
			end
			if (rx_holds_done != rx_hold_reqs) begin
				rx_holds_done++;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[SCREEN_BITS-1:0];
		if (idx == REG_SCREEN_WIDTH)
			scr_width = value[SCREEN_BITS-1:0];
		else if (idx == REG_SCREEN_HEIGHT)
			scr_height = value[SCREEN_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sampled on the falling edge so that no handshake of the same step is missed.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_lines.size() > 0 || push || expected_points.size() > 0);
	endtask

	task automatic run_random(input int count);
		@(negedge clk);
		repeat (count)
			pending_lines.push_back(random_line());
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines at the reset screen size.
		@(negedge clk);
		pending_lines.push_back(mk_line(0, 0, 0, 0, 16'h0000, 8'h00));
		pending_lines.push_back(mk_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			16'hFFFF, 8'hFF));
		pending_lines.push_back(mk_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			16'h5555, 8'd32));
		pending_lines.push_back(mk_line(0, 0, 10, 0, 16'hAAAA, 8'd32));
		pending_lines.push_back(mk_line(10, 5, 0, 5, 16'h1234, 8'h80));
		pending_lines.push_back(mk_line(3, 0, 3, 9, 16'hF00F, 8'h01));
		pending_lines.push_back(mk_line(3, 9, 3, 0, 16'h0FF0, 8'hFE));
		pending_lines.push_back(mk_line(0, 0, 7, 3, 16'h8001, 8'd32));
		pending_lines.push_back(mk_line(0, 0, 3, 7, 16'h7FFE, 8'h7F));
		pending_lines.push_back(mk_line(7, 3, 0, 0, 16'hC3C3, 8'h40));
		pending_lines.push_back(mk_line(0, 7, 3, 0, 16'h3C3C, 8'h20));
		pending_lines.push_back(mk_line(10, 10, 4, 12, 16'h0001, 8'h10));
		pending_lines.push_back(mk_line(10, 10, 12, 4, 16'h8000, 8'h08));
		// The end point falls exactly on the last allowed step, then one past it.
		pending_lines.push_back(mk_line(0, 0, STEP_COUNT - 1, 0, 16'hBEEF, 8'd32));
		pending_lines.push_back(mk_line(0, 0, STEP_COUNT, 0, 16'hCAFE, 8'd32));
		pending_lines.push_back(mk_line(COORD_MIN, 0, COORD_MAX, 0, 16'h00FF, 8'hFF));
		pending_lines.push_back(mk_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			16'hFF00, 8'h00));
		pending_lines.push_back(mk_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			16'h0F0F, 8'hF0));
		pending_lines.push_back(mk_line(315, 235, 325, 245, 16'h4242, 8'd32));
		pending_lines.push_back(mk_line(-3, -2, 4, 3, 16'h2424, 8'h55));
		pending_lines.push_back(mk_line(0, 238, 0, 241, 16'h1111, 8'hAA));
		pending_lines.push_back(mk_line(317, 0, 321, 0, 16'h2222, 8'h33));
		wait_drained();

		// Largest screen, writes past the register list in between, no idling.
		write_reg(REG_SCREEN_WIDTH, 1023);
		write_reg(REG_SPARE_A, 5);
		write_reg(REG_SCREEN_HEIGHT, 1023);
		write_reg(REG_SPARE_B, 1023);
		tx_burst = 1'b1;
		rx_burst = 1'b1;
		run_random(25);
		tx_burst = 1'b0;
		rx_burst = 1'b0;

		// A zero dimension hides every point.
		write_reg(REG_SCREEN_WIDTH, 0);
		write_reg(REG_SCREEN_HEIGHT, 600);
		run_random(12);
		write_reg(REG_SCREEN_WIDTH, 600);
		write_reg(REG_SCREEN_HEIGHT, 0);
		run_random(10);

		write_reg(REG_SCREEN_WIDTH, 1);
		write_reg(REG_SCREEN_HEIGHT, 1);
		run_random(12);

		// The consumer holds off while requests keep coming, so the block backs up.
		write_reg(REG_SCREEN_WIDTH, 640);
		write_reg(REG_SCREEN_HEIGHT, 480);
		@(negedge clk);
		rx_hold_reqs++;
		tx_burst = 1'b1;
		run_random(20);
		tx_burst = 1'b0;

		repeat (2) begin
			write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 1023));
			write_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 1023));
			run_random(12);
		end

		repeat (END_SETTLE) @(posedge clk);
		if (expected_points.size() != 0) begin
			$error("%0d expected points never arrived", expected_points.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
